[hw/rtl/csp_pkg.sv]
package csp_pkg;

   localparam int STATE_SIZE = 5;

   localparam logic [16:0] TURN_THRESHOLD_RESET = 17'd1;

   // 1/(2*pi) in Q48, split in two halves for the phase multiply
   localparam logic [45:0] INV_TWO_PI_Q48 = 46'h28BE60DB9391;
   localparam logic [22:0] K_LO = INV_TWO_PI_Q48[22:0];
   localparam logic [22:0] K_HI = INV_TWO_PI_Q48[45:23];

   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
   localparam logic [31:0] SIN_C9  = 32'd172272;
   localparam logic [31:0] HORNER_COEF [4] = '{32'd5026995, 32'd85569306,
                                               32'd693598668, 32'd1686629713};

   localparam int SINE_LAT   = 8;
   localparam int DIV_BITS   = 49;
   localparam int DIV_LAT    = DIV_BITS + 1;
   localparam int PIPE_DEPTH = 4 + SINE_LAT + 3 + DIV_LAT + 2;

   localparam int SUM_W = 53;
   localparam logic signed [31:0] OUT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] OUT_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] v;
      logic signed [31:0] yaw;
      logic signed [31:0] yawd;
      logic signed [31:0] va;
      logic signed [31:0] yawdd;
      logic        [20:0] dt;
      logic               turn;
   } front_type;

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] v;
      logic signed [31:0] yawd;
      logic signed [31:0] va;
      logic        [20:0] dt;
      logic        [26:0] d2;
      logic signed [38:0] ns;
      logic signed [38:0] nr;
      logic signed [39:0] h2;
      logic signed [43:0] nh;
      logic               turn;
   } side_a_type;

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] v;
      logic signed [31:0] yawd;
      logic signed [39:0] h2;
      logic signed [43:0] nh;
      logic signed [38:0] ns;
      logic signed [38:0] nr;
      logic               turn;
      logic signed [40:0] dxs;
      logic signed [40:0] dys;
      logic signed [45:0] nx;
      logic signed [45:0] ny;
   } side_b_type;

endpackage

[hw/rtl/csp_req_if.sv]
interface csp_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] speed;
   logic signed [31:0] heading;
   logic signed [31:0] heading_rate;
   logic signed [31:0] accel_noise;
   logic signed [31:0] heading_accel_noise;
   logic        [20:0] time_step;

   modport source (
      output valid, pos_x, pos_y, speed, heading, heading_rate, accel_noise,
             heading_accel_noise, time_step,
      input  ready
   );
   modport sink (
      input  valid, pos_x, pos_y, speed, heading, heading_rate, accel_noise,
             heading_accel_noise, time_step,
      output ready
   );
endinterface

[hw/rtl/csp_rsp_if.sv]
interface csp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] next_pos_x;
   logic signed [31:0] next_pos_y;
   logic signed [31:0] next_speed;
   logic signed [31:0] next_heading;
   logic signed [31:0] next_heading_rate;
   logic               saturated;

   modport source (
      output valid, next_pos_x, next_pos_y, next_speed, next_heading,
             next_heading_rate, saturated,
      input  ready
   );
   modport sink (
      input  valid, next_pos_x, next_pos_y, next_speed, next_heading,
             next_heading_rate, saturated,
      output ready
   );
endinterface

[hw/rtl/csp_sine.sv]
module csp_sine
   import csp_pkg::*;
(
   input  logic               clock,
   input  logic               adv,
   input  logic        [31:0] phase,
   output logic signed [31:0] sine
);
   logic [30:0] r1_in, r1_ff;
   logic        n1_ff;
   logic [61:0] sq;
   logic [31:0] x2_ff;
   logic [30:0] r2_ff;
   logic        n2_ff;
   logic [31:0] hx_ff [4];
   logic [30:0] hr_ff [4];
   logic        hn_ff [4];
   logic [31:0] ht_ff [4];
   logic [62:0] sp;
   logic [32:0] s_raw;
   logic [30:0] s_in, s_ff;
   logic        n7_ff;
   logic signed [31:0] sine_ff;

   assign r1_in = phase[30] ? (ONE_Q30 - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
   assign sq    = r1_ff * r1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         r1_ff <= r1_in;
         n1_ff <= phase[31];
         x2_ff <= sq[61:30];
         r2_ff <= r1_ff;
         n2_ff <= n1_ff;
      end
   end

   for (genvar h = 0; h < 4; h++) begin : g_horner
      logic [31:0] x_src;
      logic [31:0] t_src;
      logic [30:0] r_src;
      logic        n_src;
      logic [63:0] prod;
      logic [33:0] diff;
      if (h == 0) begin : g_first
         assign x_src = x2_ff;
         assign t_src = SIN_C9;
         assign r_src = r2_ff;
         assign n_src = n2_ff;
      end else begin : g_next
         assign x_src = hx_ff[h-1];
         assign t_src = ht_ff[h-1];
         assign r_src = hr_ff[h-1];
         assign n_src = hn_ff[h-1];
      end
      assign prod = x_src * t_src;
      assign diff = {2'b00, HORNER_COEF[h]} - prod[63:30];
      always_ff @(posedge clock) begin
         if (adv) begin
            hx_ff[h] <= x_src;
            ht_ff[h] <= diff[31:0];
            hr_ff[h] <= r_src;
            hn_ff[h] <= n_src;
         end
      end
   end

   assign sp    = hr_ff[3] * ht_ff[3];
   assign s_raw = sp[62:30];
   assign s_in  = (s_raw > {2'b00, ONE_Q30}) ? ONE_Q30 : s_raw[30:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         s_ff    <= s_in;
         n7_ff   <= hn_ff[3];
         sine_ff <= n7_ff ? -$signed({1'b0, s_ff}) : $signed({1'b0, s_ff});
      end
   end

   assign sine = sine_ff;
endmodule

[hw/rtl/csp_div.sv]
module csp_div
   import csp_pkg::*;
(
   input  logic                  clock,
   input  logic                  adv,
   input  logic [DIV_BITS-1:0]   dividend,
   input  logic [31:0]           divisor,
   input  logic                  negate,
   output logic signed [DIV_BITS:0] quotient
);
   logic [31:0]         rem_ff [DIV_BITS];
   logic [DIV_BITS-1:0] num_ff [DIV_BITS];
   logic [DIV_BITS-1:0] quo_ff [DIV_BITS];
   logic [31:0]         den_ff [DIV_BITS];
   logic                neg_ff [DIV_BITS];
   logic signed [DIV_BITS:0] quotient_ff;

   // restoring division, one quotient bit per stage
   for (genvar i = 0; i < DIV_BITS; i++) begin : g_step
      logic [31:0]         rem_src;
      logic [DIV_BITS-1:0] num_src;
      logic [DIV_BITS-1:0] quo_src;
      logic [31:0]         den_src;
      logic                neg_src;
      logic [32:0]         trial;
      logic                ge;
      if (i == 0) begin : g_first
         assign rem_src = '0;
         assign num_src = dividend;
         assign quo_src = '0;
         assign den_src = divisor;
         assign neg_src = negate;
      end else begin : g_next
         assign rem_src = rem_ff[i-1];
         assign num_src = num_ff[i-1];
         assign quo_src = quo_ff[i-1];
         assign den_src = den_ff[i-1];
         assign neg_src = neg_ff[i-1];
      end
      assign trial = {rem_src, num_src[DIV_BITS-1]};
      assign ge    = trial >= {1'b0, den_src};
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[i] <= ge ? 32'(trial - {1'b0, den_src}) : trial[31:0];
            num_ff[i] <= {num_src[DIV_BITS-2:0], 1'b0};
            quo_ff[i] <= {quo_src[DIV_BITS-2:0], ge};
            den_ff[i] <= den_src;
            neg_ff[i] <= neg_src;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         quotient_ff <= neg_ff[DIV_BITS-1] ? -$signed({1'b0, quo_ff[DIV_BITS-1]})
                                           : $signed({1'b0, quo_ff[DIV_BITS-1]});
      end
   end

   assign quotient = quotient_ff;
endmodule

[hw/rtl/ctrv_sigma_point_prediction_core.sv]
// Throughput: one item per cycle while the result is not stalled; the depth
// is set by the 8-stage sine units and the 50-stage bit-per-stage divider
// for the turning case.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
// Reset (synchronous) clears all valid bits and sets turn_threshold to 1.
module ctrv_sigma_point_prediction_core
   import csp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [16:0] csr_wdata,
   csp_req_if.sink     req_ch,
   csp_rsp_if.source   rsp_ch
);
   logic                  adv;
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic [16:0]           thr_ff;

   front_type          s1_front_in, s1_front_ff;
   logic [32:0]        yawd_mag;
   logic signed [53:0] s1_wprod_in, s1_wprod_ff;
   logic signed [53:0] s1_vadt_in, s1_vadt_ff;
   logic signed [53:0] s1_rdt_in, s1_rdt_ff;
   logic [41:0]        s1_dtsq_in, s1_dtsq_ff;

   logic signed [54:0] wr, nsr, nrr;
   logic signed [38:0] w;
   logic [42:0]        d2r;
   front_type          s2_front_ff;
   logic signed [39:0] s2_h2_in, s2_h2_ff;
   logic [26:0]        s2_d2_ff;
   logic signed [38:0] s2_ns_ff, s2_nr_ff;

   front_type          s3_front_ff;
   logic signed [39:0] s3_h2_ff;
   logic [26:0]        s3_d2_ff;
   logic signed [38:0] s3_ns_ff, s3_nr_ff;
   logic signed [63:0] s3_pyl_in, s3_pyh_in, s3_phl_in, s3_phh_in;
   logic signed [63:0] s3_pyl_ff, s3_pyh_ff, s3_phl_ff, s3_phh_ff;
   logic signed [59:0] s3_nhp_in, s3_nhp_ff;

   logic [63:0]        f0, f1;
   logic signed [60:0] nhr;
   side_a_type         s4_side_in, s4_side_ff;
   logic [31:0]        s4_p0_ff, s4_p0c_ff, s4_p1_ff, s4_p1c_ff;

   logic signed [31:0] sin0, cos0, sin1, cos1;
   side_a_type         sa_ff [SINE_LAT];

   side_a_type         m1_side_ff;
   logic signed [63:0] m1_pvc_ff, m1_pvs_ff, m1_pac_ff, m1_pas_ff;
   logic signed [32:0] m1_ds_ff, m1_dc_ff;

   logic signed [63:0] rvcr, rvsr, racr, rasr;
   side_a_type         m2_side_ff;
   logic signed [33:0] m2_rvc_ff, m2_rvs_ff, m2_rac_ff, m2_ras_ff;
   logic signed [63:0] m2_numx_ff, m2_numy_ff;

   logic [63:0]        absx, absy;
   side_a_type         m3_side_ff;
   logic signed [55:0] m3_sx_ff, m3_sy_ff;
   logic signed [61:0] m3_nxp_ff, m3_nyp_ff;
   logic [DIV_BITS-1:0] m3_nxa_ff, m3_nya_ff;
   logic               m3_negx_ff, m3_negy_ff;
   logic [31:0]        m3_den_ff;

   logic signed [56:0] sxr, syr;
   logic signed [62:0] nxr, nyr;
   side_b_type         sb_in;
   side_b_type         sb_ff [DIV_LAT];
   logic signed [DIV_BITS:0] qx, qy;

   side_b_type         fb;
   logic signed [SUM_W-1:0] dx, dy;
   logic signed [SUM_W-1:0] f1_sum_in [STATE_SIZE];
   logic signed [SUM_W-1:0] f1_sum_ff [STATE_SIZE];
   logic signed [31:0] out_in [STATE_SIZE];
   logic signed [31:0] out_ff [STATE_SIZE];
   logic [STATE_SIZE-1:0] clip;
   logic               sat_ff;

   assign adv          = !vld_ff[PIPE_DEPTH-1] || rsp_ch.ready;
   assign req_ch.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         thr_ff <= TURN_THRESHOLD_RESET;
      end else begin
         if (adv) begin
            vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_ch.valid};
         end
         if (csr_we) begin
            thr_ff <= csr_wdata;
         end
      end
   end

   // stage 1: products on the raw item, turn decision
   assign yawd_mag = req_ch.heading_rate[31] ? 33'd0 - 33'(req_ch.heading_rate)
                                             : 33'(req_ch.heading_rate);
   always_comb begin
      s1_front_in.px    = req_ch.pos_x;
      s1_front_in.py    = req_ch.pos_y;
      s1_front_in.v     = req_ch.speed;
      s1_front_in.yaw   = req_ch.heading;
      s1_front_in.yawd  = req_ch.heading_rate;
      s1_front_in.va    = req_ch.accel_noise;
      s1_front_in.yawdd = req_ch.heading_accel_noise;
      s1_front_in.dt    = req_ch.time_step;
      s1_front_in.turn  = (req_ch.heading_rate != 32'sd0) && (yawd_mag >= 33'(thr_ff));
   end
   assign s1_wprod_in = req_ch.heading_rate * $signed({1'b0, req_ch.time_step});
   assign s1_vadt_in  = req_ch.accel_noise * $signed({1'b0, req_ch.time_step});
   assign s1_rdt_in   = req_ch.heading_accel_noise * $signed({1'b0, req_ch.time_step});
   assign s1_dtsq_in  = req_ch.time_step * req_ch.time_step;

   // stage 2: rounding, turned heading
   assign wr       = 55'(s1_wprod_ff) + 55'sd32768;
   assign w        = wr[54:16];
   assign s2_h2_in = 40'(s1_front_ff.yaw) + 40'(w);
   assign d2r      = 43'(s1_dtsq_ff) + 43'd32768;
   assign nsr      = 55'(s1_vadt_ff) + 55'sd32768;
   assign nrr      = 55'(s1_rdt_ff) + 55'sd32768;

   // stage 3: angle to phase partial products
   assign s3_pyl_in = s2_front_ff.yaw * $signed({1'b0, K_LO});
   assign s3_pyh_in = s2_front_ff.yaw * $signed({1'b0, K_HI});
   assign s3_phl_in = s2_h2_ff * $signed({1'b0, K_LO});
   assign s3_phh_in = s2_h2_ff * $signed({1'b0, K_HI});
   assign s3_nhp_in = s2_front_ff.yawdd * $signed({1'b0, s2_d2_ff});

   // stage 4: phases
   assign f0  = s3_pyl_ff + (s3_pyh_ff <<< 23);
   assign f1  = s3_phl_ff + (s3_phh_ff <<< 23);
   assign nhr = 61'(s3_nhp_ff) + 61'sd65536;
   always_comb begin
      s4_side_in.px   = s3_front_ff.px;
      s4_side_in.py   = s3_front_ff.py;
      s4_side_in.v    = s3_front_ff.v;
      s4_side_in.yawd = s3_front_ff.yawd;
      s4_side_in.va   = s3_front_ff.va;
      s4_side_in.dt   = s3_front_ff.dt;
      s4_side_in.d2   = s3_d2_ff;
      s4_side_in.ns   = s3_ns_ff;
      s4_side_in.nr   = s3_nr_ff;
      s4_side_in.h2   = s3_h2_ff;
      s4_side_in.nh   = nhr[60:17];
      s4_side_in.turn = s3_front_ff.turn;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_front_ff <= s1_front_in;
         s1_wprod_ff <= s1_wprod_in;
         s1_vadt_ff  <= s1_vadt_in;
         s1_rdt_ff   <= s1_rdt_in;
         s1_dtsq_ff  <= s1_dtsq_in;

         s2_front_ff <= s1_front_ff;
         s2_h2_ff    <= s2_h2_in;
         s2_d2_ff    <= d2r[42:16];
         s2_ns_ff    <= nsr[54:16];
         s2_nr_ff    <= nrr[54:16];

         s3_front_ff <= s2_front_ff;
         s3_h2_ff    <= s2_h2_ff;
         s3_d2_ff    <= s2_d2_ff;
         s3_ns_ff    <= s2_ns_ff;
         s3_nr_ff    <= s2_nr_ff;
         s3_pyl_ff   <= s3_pyl_in;
         s3_pyh_ff   <= s3_pyh_in;
         s3_phl_ff   <= s3_phl_in;
         s3_phh_ff   <= s3_phh_in;
         s3_nhp_ff   <= s3_nhp_in;

         s4_side_ff  <= s4_side_in;
         s4_p0_ff    <= f0[63:32];
         s4_p0c_ff   <= f0[63:32] + 32'h4000_0000;
         s4_p1_ff    <= f1[63:32];
         s4_p1c_ff   <= f1[63:32] + 32'h4000_0000;
      end
   end

   csp_sine u_sin0 (.clock(clock), .adv(adv), .phase(s4_p0_ff),  .sine(sin0));
   csp_sine u_cos0 (.clock(clock), .adv(adv), .phase(s4_p0c_ff), .sine(cos0));
   csp_sine u_sin1 (.clock(clock), .adv(adv), .phase(s4_p1_ff),  .sine(sin1));
   csp_sine u_cos1 (.clock(clock), .adv(adv), .phase(s4_p1c_ff), .sine(cos1));

   for (genvar i = 0; i < SINE_LAT; i++) begin : g_side_a
      always_ff @(posedge clock) begin
         if (adv) begin
            sa_ff[i] <= (i == 0) ? s4_side_ff : sa_ff[(i == 0) ? 0 : i-1];
         end
      end
   end

   // motion and noise terms
   assign rvcr = m1_pvc_ff + 64'sd536870912;
   assign rvsr = m1_pvs_ff + 64'sd536870912;
   assign racr = m1_pac_ff + 64'sd536870912;
   assign rasr = m1_pas_ff + 64'sd536870912;
   assign absx = m2_numx_ff[63] ? 64'(-m2_numx_ff) : 64'(m2_numx_ff);
   assign absy = m2_numy_ff[63] ? 64'(-m2_numy_ff) : 64'(m2_numy_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_side_ff <= sa_ff[SINE_LAT-1];
         m1_pvc_ff  <= sa_ff[SINE_LAT-1].v * cos0;
         m1_pvs_ff  <= sa_ff[SINE_LAT-1].v * sin0;
         m1_pac_ff  <= sa_ff[SINE_LAT-1].va * cos0;
         m1_pas_ff  <= sa_ff[SINE_LAT-1].va * sin0;
         m1_ds_ff   <= 33'(sin1) - 33'(sin0);
         m1_dc_ff   <= 33'(cos0) - 33'(cos1);

         m2_side_ff <= m1_side_ff;
         m2_rvc_ff  <= rvcr[63:30];
         m2_rvs_ff  <= rvsr[63:30];
         m2_rac_ff  <= racr[63:30];
         m2_ras_ff  <= rasr[63:30];
         m2_numx_ff <= m1_side_ff.v * m1_ds_ff;
         m2_numy_ff <= m1_side_ff.v * m1_dc_ff;

         m3_side_ff <= m2_side_ff;
         m3_sx_ff   <= m2_rvc_ff * $signed({1'b0, m2_side_ff.dt});
         m3_sy_ff   <= m2_rvs_ff * $signed({1'b0, m2_side_ff.dt});
         m3_nxp_ff  <= m2_rac_ff * $signed({1'b0, m2_side_ff.d2});
         m3_nyp_ff  <= m2_ras_ff * $signed({1'b0, m2_side_ff.d2});
         m3_nxa_ff  <= absx[62:14];
         m3_nya_ff  <= absy[62:14];
         m3_negx_ff <= m2_numx_ff[63] ^ m2_side_ff.yawd[31];
         m3_negy_ff <= m2_numy_ff[63] ^ m2_side_ff.yawd[31];
         m3_den_ff  <= m2_side_ff.yawd[31] ? 32'(-m2_side_ff.yawd) : 32'(m2_side_ff.yawd);
      end
   end

   csp_div u_div_x (
      .clock(clock), .adv(adv), .dividend(m3_nxa_ff), .divisor(m3_den_ff),
      .negate(m3_negx_ff), .quotient(qx)
   );
   csp_div u_div_y (
      .clock(clock), .adv(adv), .dividend(m3_nya_ff), .divisor(m3_den_ff),
      .negate(m3_negy_ff), .quotient(qy)
   );

   assign sxr = 57'(m3_sx_ff) + 57'sd32768;
   assign syr = 57'(m3_sy_ff) + 57'sd32768;
   assign nxr = 63'(m3_nxp_ff) + 63'sd65536;
   assign nyr = 63'(m3_nyp_ff) + 63'sd65536;
   always_comb begin
      sb_in.px   = m3_side_ff.px;
      sb_in.py   = m3_side_ff.py;
      sb_in.v    = m3_side_ff.v;
      sb_in.yawd = m3_side_ff.yawd;
      sb_in.h2   = m3_side_ff.h2;
      sb_in.nh   = m3_side_ff.nh;
      sb_in.ns   = m3_side_ff.ns;
      sb_in.nr   = m3_side_ff.nr;
      sb_in.turn = m3_side_ff.turn;
      sb_in.dxs  = sxr[56:16];
      sb_in.dys  = syr[56:16];
      sb_in.nx   = nxr[62:17];
      sb_in.ny   = nyr[62:17];
   end

   for (genvar i = 0; i < DIV_LAT; i++) begin : g_side_b
      always_ff @(posedge clock) begin
         if (adv) begin
            sb_ff[i] <= (i == 0) ? sb_in : sb_ff[(i == 0) ? 0 : i-1];
         end
      end
   end

   // final sums and saturation
   assign fb = sb_ff[DIV_LAT-1];
   assign dx = fb.turn ? SUM_W'(qx) : SUM_W'(fb.dxs);
   assign dy = fb.turn ? SUM_W'(qy) : SUM_W'(fb.dys);
   assign f1_sum_in[0] = SUM_W'(fb.px) + dx + SUM_W'(fb.nx);
   assign f1_sum_in[1] = SUM_W'(fb.py) + dy + SUM_W'(fb.ny);
   assign f1_sum_in[2] = SUM_W'(fb.v) + SUM_W'(fb.ns);
   assign f1_sum_in[3] = SUM_W'(fb.h2) + SUM_W'(fb.nh);
   assign f1_sum_in[4] = SUM_W'(fb.yawd) + SUM_W'(fb.nr);

   always_comb begin
      for (int k = 0; k < STATE_SIZE; k++) begin
         if (f1_sum_ff[k] > SUM_W'(OUT_MAX)) begin
            out_in[k] = OUT_MAX;
            clip[k]   = 1'b1;
         end else if (f1_sum_ff[k] < SUM_W'(OUT_MIN)) begin
            out_in[k] = OUT_MIN;
            clip[k]   = 1'b1;
         end else begin
            out_in[k] = f1_sum_ff[k][31:0];
            clip[k]   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_sum_ff <= f1_sum_in;
         out_ff    <= out_in;
         sat_ff    <= |clip;
      end
   end

   assign rsp_ch.valid             = vld_ff[PIPE_DEPTH-1];
   assign rsp_ch.next_pos_x        = out_ff[0];
   assign rsp_ch.next_pos_y        = out_ff[1];
   assign rsp_ch.next_speed        = out_ff[2];
   assign rsp_ch.next_heading      = out_ff[3];
   assign rsp_ch.next_heading_rate = out_ff[4];
   assign rsp_ch.saturated         = sat_ff;

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> vld_ff[0])
      else $error("accepted item did not enter the pipeline");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=> $stable(vld_ff))
      else $error("pipeline moved while the result was stalled");

   a_sat_clipped: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.saturated) |->
         (rsp_ch.next_pos_x == OUT_MAX || rsp_ch.next_pos_x == OUT_MIN ||
          rsp_ch.next_pos_y == OUT_MAX || rsp_ch.next_pos_y == OUT_MIN ||
          rsp_ch.next_speed == OUT_MAX || rsp_ch.next_speed == OUT_MIN ||
          rsp_ch.next_heading == OUT_MAX || rsp_ch.next_heading == OUT_MIN ||
          rsp_ch.next_heading_rate == OUT_MAX || rsp_ch.next_heading_rate == OUT_MIN))
      else $error("saturated flag without a clipped field");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");
endmodule
